### rtl/core/bchj_pkg.sv
// Shared types and constants for the bucket-chain hash join block.
package bchj_pkg;

  localparam int MAX_TUPLES_DEF      = 64;
  localparam int MAX_SUB_BUCKETS_DEF = 64;
  localparam int TABLE_ROWS_DEF      = 4;
  localparam int MAX_PAYLOADS_DEF    = 2;
  localparam int KEY_WIDTH_DEF       = 32;
  localparam int SLOTS               = 4;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_PROBE = 2'd2;

  localparam logic [1:0] REG_HASH_BITS = 2'd0;
  localparam logic [1:0] REG_PAYLOADS  = 2'd1;
  localparam logic [1:0] REG_BUILD_MSK = 2'd2;
  localparam logic [1:0] REG_PROBE_MSK = 2'd3;

  localparam logic [1:0] ST_NO_MATCH = 2'd0;
  localparam logic [1:0] ST_JOINED   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_BUILD, S_STORE, S_PROBE_HEAD, S_PROBE_READ, S_PROBE_CMP, S_PROBE_END
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;     // latch the input item
    logic clear_step;  // clear one head, advance sweep
    logic clear_done;  // reset count and overflow
    logic build;       // store the captured tuple
    logic head_rd;     // read the sub-bucket head
    logic entry_rd;    // read the current entry
    logic cmp;         // compare, maybe emit, follow link
    logic emit_none;   // emit the no-match result
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;
    logic mode_clear;
    logic mode_build;
    logic mode_probe;
    logic chain_end;  // current index is the empty marker
    logic any_match;
  } sts_t;

endpackage

### rtl/core/bchj_ctrl.sv
// Controller state machine for the hash join.
module bchj_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bchj_pkg::sts_t sts,
  output bchj_pkg::ctl_t ctl
);
  import bchj_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_BUILD;
      S_BUILD: begin
        if (sts.mode_clear) state_next = S_CLEAR;
        else if (sts.mode_probe) state_next = S_PROBE_HEAD;
        else if (sts.mode_build) state_next = S_STORE;
        else state_next = S_IDLE;
      end
      S_STORE: state_next = S_IDLE;
      S_CLEAR: if (sts.clear_last) state_next = S_IDLE;
      S_PROBE_HEAD: state_next = S_PROBE_READ;
      S_PROBE_READ: state_next = sts.chain_end ? S_PROBE_END : S_PROBE_CMP;
      S_PROBE_CMP: state_next = S_PROBE_READ;
      S_PROBE_END: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: ctl.capture = start;
      S_BUILD: ;
      S_STORE: ctl.build = 1'b1;
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        ctl.clear_done = sts.clear_last;
      end
      S_PROBE_HEAD: ctl.head_rd = 1'b1;
      S_PROBE_READ: ctl.entry_rd = !sts.chain_end;
      S_PROBE_CMP: ctl.cmp = 1'b1;
      S_PROBE_END: ctl.emit_none = !sts.any_match;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> busy)
    else $error("busy not raised after a start");
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.build, ctl.clear_step, ctl.head_rd, ctl.entry_rd, ctl.cmp, ctl.emit_none}))
    else $error("more than one datapath command");
  assert property (@(posedge clk) disable iff (rst)
    ctl.cmp |=> (state == S_PROBE_READ))
    else $error("compare not followed by a read");
endmodule

### rtl/core/bchj_dp.sv
// Datapath of the hash join: table memories, chain walk and result forming.
module bchj_dp #(
  parameter int MAX_TUPLES      = bchj_pkg::MAX_TUPLES_DEF,
  parameter int MAX_SUB_BUCKETS = bchj_pkg::MAX_SUB_BUCKETS_DEF,
  parameter int TABLE_ROWS      = bchj_pkg::TABLE_ROWS_DEF,
  parameter int MAX_PAYLOADS    = bchj_pkg::MAX_PAYLOADS_DEF,
  parameter int KEY_WIDTH       = bchj_pkg::KEY_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  bchj_pkg::ctl_t ctl,
  output bchj_pkg::sts_t sts,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [3:0]     cfg_data,
  input  logic [1:0]     mode,
  input  logic [31:0]    key_first,
  input  logic [31:0]    key_second,
  input  logic [31:0]    row_a,
  input  logic [31:0]    row_b,
  input  logic [31:0]    row_c,
  input  logic [31:0]    row_d,
  output logic           result_valid,
  output logic [1:0]     status,
  output logic [31:0]    out_row_a,
  output logic [31:0]    out_row_b,
  output logic [31:0]    out_row_c,
  output logic [31:0]    out_row_d,
  output logic           last
);
  import bchj_pkg::*;

  localparam int IW = $clog2(MAX_TUPLES + 1);
  localparam int HW = (MAX_SUB_BUCKETS > 1) ? $clog2(MAX_SUB_BUCKETS) : 1;
  localparam int KW = KEY_WIDTH;
  localparam logic [IW-1:0] EMPTY = IW'(MAX_TUPLES);

  logic [2:0] hash_bits;
  logic [1:0] payloads_in_use;
  logic [3:0] build_rows_mask, probe_rows_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_bits <= 3'd4;
      payloads_in_use <= 2'd1;
      build_rows_mask <= 4'd1;
      probe_rows_mask <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HASH_BITS: hash_bits <= cfg_data[2:0];
        REG_PAYLOADS:  payloads_in_use <= cfg_data[1:0];
        REG_BUILD_MSK: build_rows_mask <= cfg_data;
        REG_PROBE_MSK: probe_rows_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  logic            two_keys;
  assign two_keys = (MAX_PAYLOADS >= 2) && (payloads_in_use >= 2'd2);

  // Captured item.
  logic [1:0]    c_mode;
  logic [KW-1:0] c_k0, c_k1;
  logic [31:0]   c_row [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      c_mode <= mode;
      c_k0 <= key_first[KW-1:0];
      c_k1 <= key_second[KW-1:0];
      c_row[0] <= row_a;
      c_row[1] <= row_b;
      c_row[2] <= row_c;
      c_row[3] <= row_d;
    end
  end

  // Sub-bucket select: low hash_bits bits, folded modulo the bucket count
  // by compare and subtract of the shifted bucket count.
  logic [6:0] hmask;
  logic [HW-1:0] bucket;
  logic [6:0] kmasked;
  logic [6:0] bucket_rem;
  assign hmask = 7'((8'd1 << hash_bits) - 8'd1);
  assign kmasked = 7'(c_k0) & hmask;
  always_comb begin
    bucket_rem = kmasked;
    for (int k = 6; k >= 0; k--) begin
      if ((MAX_SUB_BUCKETS << k) <= 127 && bucket_rem >= 7'(MAX_SUB_BUCKETS << k))
        bucket_rem = bucket_rem - 7'(MAX_SUB_BUCKETS << k);
    end
    bucket = HW'(bucket_rem);
  end

  // Heads with valid bits (cleared by a sweep on clear, at once on reset).
  logic [IW-1:0] heads [MAX_SUB_BUCKETS];
  logic [MAX_SUB_BUCKETS-1:0] head_valid;
  logic [IW-1:0] head_q;
  logic [HW-1:0] sweep;
  logic [IW-1:0] count;
  logic          overflow;
  logic [IW-1:0] cur;
  logic          any_match;

  assign sts.clear_last = (sweep == HW'(MAX_SUB_BUCKETS - 1));
  assign sts.mode_clear = (c_mode == MODE_CLEAR);
  assign sts.mode_build = (c_mode == MODE_BUILD);
  assign sts.mode_probe = (c_mode == MODE_PROBE);
  assign sts.chain_end  = (cur == EMPTY);
  assign sts.any_match  = any_match;

  logic full;
  assign full = (count == IW'(MAX_TUPLES));
  logic [$clog2(MAX_TUPLES)-1:0] widx;
  assign widx = count[$clog2(MAX_TUPLES)-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
      sweep <= '0;
      count <= '0;
      overflow <= 1'b0;
    end else begin
      if (ctl.clear_step) begin
        head_valid[sweep] <= 1'b0;
        sweep <= sts.clear_last ? '0 : sweep + HW'(1);
      end
      if (ctl.clear_done) begin
        count <= '0;
        overflow <= 1'b0;
      end
      if (ctl.build) begin
        if (full) overflow <= 1'b1;
        else begin
          head_valid[bucket] <= 1'b1;
          count <= count + IW'(1);
        end
      end
    end
  end

  // The head of the selected sub-bucket is read into a register every cycle.
  always_ff @(posedge clk) begin
    if (ctl.build && !full) heads[bucket] <= count;
    head_q <= head_valid[bucket] ? heads[bucket] : EMPTY;
  end

  // Tuple store memories, one read port each.
  logic [IW-1:0]   links  [MAX_TUPLES];
  logic [2*KW-1:0] keys   [MAX_TUPLES];
  logic [31:0]     rows_m [MAX_TUPLES][SLOTS];
  logic [IW-1:0]   rd_link;
  logic [2*KW-1:0] rd_key;
  logic [31:0]     rd_row [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.build && !full) begin
      links[widx] <= head_q;
      keys[widx] <= {c_k1, c_k0};
      for (int s = 0; s < SLOTS; s++)
        rows_m[widx][s] <= (s < TABLE_ROWS) ? c_row[s] : 32'd0;
    end
    if (ctl.entry_rd) begin
      rd_link <= links[cur[$clog2(MAX_TUPLES)-1:0]];
      rd_key <= keys[cur[$clog2(MAX_TUPLES)-1:0]];
      for (int s = 0; s < SLOTS; s++) rd_row[s] <= rows_m[cur[$clog2(MAX_TUPLES)-1:0]][s];
    end
  end

  logic match;
  assign match = (rd_key[KW-1:0] == c_k0) && (!two_keys || rd_key[2*KW-1:KW] == c_k1);

  // Chain walk. A joined row is held one step so that last can be set on the final one.
  logic          pend;
  logic [31:0]   pend_row [SLOTS];
  logic          flush;

  // Chain ended with a held row: it goes out as the final one.
  assign flush = pend && sts.chain_end && !ctl.entry_rd && !ctl.head_rd && !ctl.cmp
                 && any_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      any_match <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.emit_none || flush || (ctl.cmp && match && pend);
      if (ctl.head_rd) begin
        cur <= head_q;
        any_match <= 1'b0;
        pend <= 1'b0;
      end
      if (ctl.cmp) begin
        cur <= rd_link;
        if (match) begin
          any_match <= 1'b1;
          pend <= 1'b1;
          if (pend) begin
            status <= ST_JOINED;
            last <= 1'b0;
            out_row_a <= pend_row[0];
            out_row_b <= pend_row[1];
            out_row_c <= pend_row[2];
            out_row_d <= pend_row[3];
          end
          for (int s = 0; s < SLOTS; s++) begin
            if (s >= TABLE_ROWS) pend_row[s] <= 32'd0;
            else if (build_rows_mask[s]) pend_row[s] <= rd_row[s];
            else if (probe_rows_mask[s]) pend_row[s] <= c_row[s];
            else pend_row[s] <= 32'd0;
          end
        end
      end
      if (ctl.emit_none) begin
        status <= overflow ? ST_OVERFLOW : ST_NO_MATCH;
        last <= 1'b1;
        out_row_a <= '0;
        out_row_b <= '0;
        out_row_c <= '0;
        out_row_d <= '0;
      end else if (flush) begin
        status <= ST_JOINED;
        last <= 1'b1;
        out_row_a <= pend_row[0];
        out_row_b <= pend_row[1];
        out_row_c <= pend_row[2];
        out_row_d <= pend_row[3];
        pend <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    ctl.build && !full |=> count == $past(count) + IW'(1))
    else $error("tuple count did not advance");
  assert property (@(posedge clk) disable iff (rst)
    count <= IW'(MAX_TUPLES))
    else $error("tuple count beyond capacity");
  assert property (@(posedge clk) disable iff (rst)
    ctl.emit_none |-> !pend)
    else $error("no-match result with a held row");
endmodule

### rtl/core/bucket_chain_hash_join.sv
// Top level of the bucket-chain hash join engine.
//
//  channel   signals                                 transfer when
//  input     start, busy, mode, key_*, row_*         start && !busy
//  config    cfg_we, cfg_index, cfg_data             cfg_we
//  result    result_valid, status, out_row_*, last   result_valid
//
// A clear sweeps the heads, one per cycle.
// A build goes through transfer, registered head read and store.
// A probe reads the sub-bucket head through a register, then walks the chain through
// the single read port of the tuple store, one entry read and one compare per entry.
// Reset is synchronous, active high, and empties the table at once.
// Results appear for one cycle each; the receiver cannot stall them.
module bucket_chain_hash_join #(
  parameter int MAX_TUPLES      = bchj_pkg::MAX_TUPLES_DEF,
  parameter int MAX_SUB_BUCKETS = bchj_pkg::MAX_SUB_BUCKETS_DEF,
  parameter int TABLE_ROWS      = bchj_pkg::TABLE_ROWS_DEF,
  parameter int MAX_PAYLOADS    = bchj_pkg::MAX_PAYLOADS_DEF,
  parameter int KEY_WIDTH       = bchj_pkg::KEY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic [1:0]  mode,
  input  logic [31:0] key_first,
  input  logic [31:0] key_second,
  input  logic [31:0] row_a,
  input  logic [31:0] row_b,
  input  logic [31:0] row_c,
  input  logic [31:0] row_d,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [31:0] out_row_a,
  output logic [31:0] out_row_b,
  output logic [31:0] out_row_c,
  output logic [31:0] out_row_d,
  output logic        last
);
  import bchj_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // The controller sequences clear, build and the chain walk of a probe.
  bchj_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  // The datapath holds the table and forms the joined rows.
  bchj_dp #(
    .MAX_TUPLES(MAX_TUPLES), .MAX_SUB_BUCKETS(MAX_SUB_BUCKETS),
    .TABLE_ROWS(TABLE_ROWS), .MAX_PAYLOADS(MAX_PAYLOADS), .KEY_WIDTH(KEY_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mode(mode), .key_first(key_first), .key_second(key_second),
    .row_a(row_a), .row_b(row_b), .row_c(row_c), .row_d(row_d),
    .result_valid(result_valid), .status(status),
    .out_row_a(out_row_a), .out_row_b(out_row_b),
    .out_row_c(out_row_c), .out_row_d(out_row_d), .last(last)
  );
endmodule

### verif/bucket_chain_hash_join_checker.sv
// Join-result predictor and comparator for the bucket-chain hash join block.
`timescale 1ns / 100ps
module bucket_chain_hash_join_checker
  import bchj_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic [1:0]  mode,
  input  logic [31:0] key_first,
  input  logic [31:0] key_second,
  input  logic [31:0] row_a,
  input  logic [31:0] row_b,
  input  logic [31:0] row_c,
  input  logic [31:0] row_d,
  input  logic        result_valid,
  input  logic [1:0]  status,
  input  logic [31:0] out_row_a,
  input  logic [31:0] out_row_b,
  input  logic [31:0] out_row_c,
  input  logic [31:0] out_row_d,
  input  logic        last,
  output int          fail_count,
  output int          pending_rows
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] row_a;
    logic [31:0] row_b;
    logic [31:0] row_c;
    logic [31:0] row_d;
    logic        last;
  } join_row_t;

  join_row_t   expected_rows[$];
  logic [2:0]  hash_bits_q;
  logic [1:0]  payloads_q;
  logic [3:0]  build_mask_q;
  logic [3:0]  probe_mask_q;
  logic [6:0]  heads[64];
  logic [6:0]  links[64];
  logic [31:0] keys_lo[64];
  logic [31:0] keys_hi[64];
  logic [31:0] rows_mem[64][4];
  int          count_q;
  logic        overflow_q;

  assign pending_rows = expected_rows.size();

  function automatic logic [5:0] bucket_of(logic [31:0] k);
    return 6'(k & ((32'd1 << hash_bits_q) - 32'd1));
  endfunction

  task automatic join_item(logic [1:0] m, logic [31:0] k0, logic [31:0] k1,
                           logic [31:0] r [4]);
    logic [6:0]  idx;
    logic [31:0] v [4];
    join_row_t   jr;
    int          hits;
    hits = 0;
    case (m)
      MODE_CLEAR: begin
        for (int i = 0; i < 64; i++) heads[i] = 7'd64;
        count_q = 0;
        overflow_q = 1'b0;
      end
      MODE_BUILD: begin
        if (count_q >= 64) begin
          overflow_q = 1'b1;
        end else begin
          keys_lo[count_q] = k0;
          keys_hi[count_q] = k1;
          for (int s = 0; s < 4; s++) rows_mem[count_q][s] = r[s];
          links[count_q] = heads[bucket_of(k0)];
          heads[bucket_of(k0)] = 7'(count_q);
          count_q++;
        end
      end
      MODE_PROBE: begin
        idx = heads[bucket_of(k0)];
        for (int st = 0; st < 64 && idx < 7'd64; st++) begin
          if (keys_lo[idx] == k0 && (payloads_q < 2 || keys_hi[idx] == k1)) begin
            for (int s = 0; s < 4; s++)
              v[s] = build_mask_q[s] ? rows_mem[idx][s] : (probe_mask_q[s] ? r[s] : 32'd0);
            expected_rows.push_back({ST_JOINED, v[0], v[1], v[2], v[3], 1'b0});
            hits++;
          end
          idx = links[idx];
        end
        if (hits == 0) begin
          expected_rows.push_back({overflow_q ? ST_OVERFLOW : ST_NO_MATCH,
                                   32'd0, 32'd0, 32'd0, 32'd0, 1'b1});
        end else begin
          jr = expected_rows.pop_back();
          jr.last = 1'b1;
          expected_rows.push_back(jr);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    logic [31:0] r [4];
    join_row_t   got;
    join_row_t   want;
    if (rst) begin
      hash_bits_q  <= 3'd4;
      payloads_q   <= 2'd1;
      build_mask_q <= 4'd1;
      probe_mask_q <= 4'd2;
      for (int i = 0; i < 64; i++) heads[i] = 7'd64;
      count_q    = 0;
      overflow_q = 1'b0;
      fail_count <= 0;
      expected_rows.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HASH_BITS: hash_bits_q  <= cfg_data[2:0];
          REG_PAYLOADS:  payloads_q   <= cfg_data[1:0];
          REG_BUILD_MSK: build_mask_q <= cfg_data;
          REG_PROBE_MSK: probe_mask_q <= cfg_data;
          default: ;
        endcase
      end
      // Compare before predicting: a result cannot stem from the same edge's transfer.
      if (result_valid) begin
        got = {status, out_row_a, out_row_b, out_row_c, out_row_d, last};
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_rows.pop_front();
          if (got !== want) begin
            $display("%0t: expected %h actual %h", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        r[0] = row_a; r[1] = row_b; r[2] = row_c; r[3] = row_d;
        join_item(mode, key_first, key_second, r);
      end
    end
  end

endmodule

### verif/bucket_chain_hash_join_test.sv
// Stimulus and verdict for the bucket-chain hash join block.
`timescale 1ns / 100ps
module bucket_chain_hash_join_test;
  import bchj_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_HASH_BITS;
  logic [3:0]  cfg_data = 4'd0;
  logic [1:0]  mode = MODE_CLEAR;
  logic [31:0] key_first = 32'd0;
  logic [31:0] key_second = 32'd0;
  logic [31:0] row_a = 32'd0;
  logic [31:0] row_b = 32'd0;
  logic [31:0] row_c = 32'd0;
  logic [31:0] row_d = 32'd0;
  logic        result_valid;
  logic [1:0]  status;
  logic [31:0] out_row_a, out_row_b, out_row_c, out_row_d;
  logic        last;
  int          fail_count;
  int          pending_rows;

  // Keys the random part reuses so that probes actually find chains.
  logic [31:0] key_pool[8];
  logic [31:0] key2_pool[8];

  always #4 clk = ~clk;

  bucket_chain_hash_join DUT (.*);
  bucket_chain_hash_join_checker monitor (.*);

  // One input transfer: optional idle gap, then hold start until the block takes it.
  // Start stays high into the next item when there is no gap; the block is busy
  // right after a transfer, so nothing is taken twice.
  task automatic send_item(logic [1:0] m, logic [31:0] k0, logic [31:0] k1,
                           logic [31:0] ra, logic [31:0] rb, logic [31:0] rc,
                           logic [31:0] rd, bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(15) : 0;
    if ($urandom_range(3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m; key_first <= k0; key_second <= k1;
    row_a <= ra; row_b <= rb; row_c <= rc; row_d <= rd;
    do @(posedge clk); while (busy);
  endtask

  // Register writes happen only once the block is idle: all expected results
  // have arrived and the longest item (a clear sweep) has had time to finish.
  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    start <= 1'b0;
    while (pending_rows != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int          pick;
    logic [1:0]  m;
    logic [31:0] k0;
    logic [31:0] k1;
    pick = $urandom_range(99);
    // Mostly builds and probes on a small key pool; rare clears, undefined
    // modes and fully random keys keep the noise in.
    if (pick < 3) m = MODE_CLEAR;
    else if (pick < 5) m = 2'd3;
    else if (pick < 50) m = MODE_BUILD;
    else m = MODE_PROBE;
    k0 = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(7)];
    k1 = ($urandom_range(3) == 0) ? $urandom() : key2_pool[$urandom_range(7)];
    send_item(m, k0, k1, $urandom(), $urandom(), $urandom(), $urandom(), 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, extremes of every field, a probe on an empty
    // table, a match, an unmatched key and the undefined mode.
    send_item(MODE_PROBE, 32'd5, 32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 1'b0);
    send_item(MODE_BUILD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(MODE_BUILD, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_item(MODE_BUILD, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_A5A5,
              32'h5A5A_5A5A, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0);
    send_item(MODE_PROBE, 32'hFFFF_FFFF, 32'h0, 32'h1111, 32'h2222, 32'h3333,
              32'h4444, 1'b0);
    send_item(MODE_PROBE, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(MODE_PROBE, 32'h0000_000F, 32'h0, 32'h1, 32'h1, 32'h1, 32'h1, 1'b0);
    send_item(2'd3, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);

    // Two keys compared, every slot from the build side.
    write_reg(REG_PAYLOADS, 4'd2);
    write_reg(REG_BUILD_MSK, 4'hF);
    write_reg(REG_PROBE_MSK, 4'h0);
    send_item(MODE_PROBE, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 32'h0, 32'h0,
              32'h0, 1'b0);
    send_item(MODE_PROBE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
              32'h0, 1'b0);

    // Fill the table past capacity in one sub-bucket: overflow and a long chain.
    write_reg(REG_HASH_BITS, 4'd0);
    write_reg(REG_PAYLOADS, 4'd1);
    write_reg(REG_BUILD_MSK, 4'h0);
    write_reg(REG_PROBE_MSK, 4'hF);
    send_item(MODE_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    for (int i = 0; i < 66; i++)
      send_item(MODE_BUILD, 32'h77, 32'(i), 32'(i), 32'(i), 32'(i), 32'(i), 1'b0);
    send_item(MODE_PROBE, 32'h77, 32'h0, 32'hDEAD, 32'hBEEF, 32'h1, 32'h2, 1'b0);
    send_item(MODE_PROBE, 32'h78, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_item(MODE_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_item(MODE_PROBE, 32'h77, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);

    // Random phases, each with its own settings; payloads 0 and 3 saturate.
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 8; i++) begin
        key_pool[i]  = (ph % 2) ? $urandom() : 32'($urandom_range(15));
        key2_pool[i] = $urandom_range(1) ? $urandom() : 32'($urandom_range(3));
      end
      write_reg(REG_HASH_BITS, (ph == 5) ? 4'd7 : 4'($urandom_range(7)));
      write_reg(REG_PAYLOADS, 4'(ph % 4));
      write_reg(REG_BUILD_MSK, 4'($urandom_range(15)));
      write_reg(REG_PROBE_MSK, 4'($urandom_range(15)));
      send_item(MODE_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
      for (int i = 0; i < 24; i++) random_item();
    end

    start <= 1'b0;
    while (pending_rows != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("bucket_chain_hash_join test passed");
    end else begin
      $display("bucket_chain_hash_join test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("bucket_chain_hash_join test failed");
    $finish;
  end

endmodule
